### src/ugtl_pkg.sv
// Shared types and constants for the glyph table and UTF-8 text layout block.
// No dependencies.
package ugtl_pkg;
  localparam int GLYPH_SLOTS = 256;
  localparam int SLOT_W = $clog2(GLYPH_SLOTS);
  localparam int CNT_W = $clog2(GLYPH_SLOTS + 1);

  localparam logic [1:0] ST_PLACED  = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_STORED  = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [1:0] REG_ROW_PITCH = 2'd0;
  localparam logic [1:0] REG_SCALE     = 2'd1;
  localparam logic [1:0] REG_ORIGIN_X  = 2'd2;
  localparam logic [1:0] REG_ORIGIN_Y  = 2'd3;

  localparam logic [15:0] CODE_NEWLINE  = 16'h000A;
  localparam logic [15:0] CODE_QUESTION = 16'h003F;

  typedef struct packed {
    logic [15:0] h;
    logic [15:0] w;
    logic [15:0] y;
    logic [15:0] x;
  } rect_t;

  typedef struct packed {
    logic signed [15:0] adv;
    logic signed [15:0] oy;
    logic signed [15:0] ox;
  } metrics_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -34'sh0_8000_0000) return -32'sh8000_0000;
    return v[31:0];
  endfunction
endpackage

### src/utf8_glyph_text_layout.sv
// Top level: glyph table in block memories, UTF-8 decoder, pen tracking.
// Depends on ugtl_pkg.
//
// One item at a time: an item is accepted when start is high and busy is low;
// busy rises on the next cycle and drops in the cycle that carries the result
// strobe. Lead and middle bytes of a multi-byte sequence finish at the
// accepting edge without raising busy and give no result; a newline passes
// through S_MUL and S_SUM, giving no result. A lookup reads each filled slot
// in S_SCAN and compares it in S_CMP, so it stops at the first hit; a missing
// glyph, or a store that finds no match, walks every filled slot first. The
// receiver cannot stall: the result strobe is high for exactly one cycle.
// Registers are taken only while idle with start low. No clearing pass after
// reset: a fill count covers the table.
module utf8_glyph_text_layout (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic func,
  input  logic first,
  input  logic [7:0] text_byte,
  input  logic [15:0] glyph_code,
  input  logic [15:0] atlas_x,
  input  logic [15:0] atlas_y,
  input  logic [15:0] glyph_w,
  input  logic [15:0] glyph_h,
  input  logic signed [15:0] off_x,
  input  logic signed [15:0] off_y,
  input  logic signed [15:0] advance,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data,
  output logic result_valid,
  output logic [1:0] status,
  output logic [15:0] code_point,
  output logic [15:0] src_x,
  output logic [15:0] src_y,
  output logic [15:0] src_w,
  output logic [15:0] src_h,
  output logic signed [31:0] dst_x,
  output logic signed [31:0] dst_y,
  output logic [27:0] dst_w,
  output logic [27:0] dst_h
);
  import ugtl_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCAN  = 8'b0000_0010,
    S_CMP   = 8'b0000_0100,
    S_STORE = 8'b0000_1000,
    S_READ  = 8'b0001_0000,
    S_MUL   = 8'b0010_0000,
    S_SUM   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state;

  logic [16:0]    tag_mem  [GLYPH_SLOTS];
  rect_t          rect_mem [GLYPH_SLOTS];
  metrics_t       met_mem  [GLYPH_SLOTS];
  logic [16:0]    tag_rd;
  rect_t          rect_rd;
  metrics_t       met_rd;

  logic [15:0] row_pitch;
  logic [11:0] scale;
  logic signed [23:0] origin_x, origin_y;
  logic signed [31:0] pen_x, pen_y;
  logic [15:0] partial_code;
  logic [1:0]  bytes_left;
  logic [CNT_W-1:0] entry_count;

  logic        op_store;
  logic [15:0] code;
  rect_t       op_rect;
  metrics_t    op_met;
  logic [CNT_W-1:0] idx;
  logic        found;
  logic [SLOT_W-1:0] hit;
  logic        newline;

  logic signed [28:0] p_ox, p_oy, p_adv;
  logic [27:0] p_w, p_h;
  logic [27:0] p_lh;

  assign busy = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !start;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pitch <= '0;
      scale <= 12'd256;
      origin_x <= '0;
      origin_y <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROW_PITCH:   row_pitch <= cfg_data[15:0];
        REG_SCALE:       scale <= cfg_data[11:0];
        REG_ORIGIN_X:    origin_x <= cfg_data[23:0];
        REG_ORIGIN_Y:    origin_y <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  logic             mem_we;
  logic [SLOT_W-1:0] mem_wa;
  logic [SLOT_W-1:0] rd_addr;

  assign mem_we = (state == S_STORE) && (found || entry_count < CNT_W'(GLYPH_SLOTS));
  assign mem_wa = found ? hit : entry_count[SLOT_W-1:0];
  assign rd_addr = (state == S_READ) ? hit : idx[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem[mem_wa]  <= {1'b1, code};
      rect_mem[mem_wa] <= op_rect;
      met_mem[mem_wa]  <= op_met;
    end
    tag_rd  <= tag_mem[rd_addr];
    rect_rd <= rect_mem[rd_addr];
    met_rd  <= met_mem[rd_addr];
  end

  logic [15:0] dec_code;
  logic        dec_emit;
  logic [15:0] pc_next;
  logic [1:0]  bl_next;

  always_comb begin
    logic [15:0] pc;
    logic [1:0]  bl;
    pc = first ? 16'd0 : partial_code;
    bl = first ? 2'd0 : bytes_left;
    dec_emit = 1'b0;
    dec_code = CODE_QUESTION;
    pc_next = pc;
    bl_next = bl;
    if (bl == 2'd2) begin
      pc_next = pc | {4'd0, text_byte[5:0], 6'd0};
      bl_next = 2'd1;
    end else if (bl == 2'd1) begin
      dec_code = pc | {10'd0, text_byte[5:0]};
      dec_emit = 1'b1;
      pc_next = '0;
      bl_next = 2'd0;
    end else if (!text_byte[7]) begin
      dec_code = {8'd0, text_byte};
      dec_emit = 1'b1;
    end else if (text_byte[7:5] == 3'b110) begin
      pc_next = {5'd0, text_byte[4:0], 6'd0};
      bl_next = 2'd1;
    end else if (text_byte[7:4] == 4'b1110) begin
      pc_next = {text_byte[3:0], 12'd0};
      bl_next = 2'd2;
    end else begin
      dec_emit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      entry_count <= '0;
      pen_x <= '0;
      pen_y <= '0;
      partial_code <= '0;
      bytes_left <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_store <= !func;
            op_rect <= '{h: glyph_h, w: glyph_w, y: atlas_y, x: atlas_x};
            op_met <= '{adv: advance, oy: off_y, ox: off_x};
            idx <= '0;
            found <= 1'b0;
            newline <= 1'b0;
            if (!func) begin
              code <= glyph_code;
              state <= S_SCAN;
            end else begin
              if (first) begin
                pen_x <= 32'(origin_x);
                pen_y <= 32'(origin_y);
              end
              partial_code <= pc_next;
              bytes_left <= bl_next;
              code <= dec_code;
              newline <= dec_code == CODE_NEWLINE;
              if (dec_emit) state <= (dec_code == CODE_NEWLINE) ? S_MUL : S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (idx >= entry_count) state <= op_store ? S_STORE : S_READ;
          else state <= S_CMP;
        end
        S_CMP: begin
          if (tag_rd == {1'b1, code}) begin
            found <= 1'b1;
            hit <= idx[SLOT_W-1:0];
            state <= op_store ? S_STORE : S_READ;
          end else begin
            idx <= idx + 1'b1;
            state <= S_SCAN;
          end
        end
        S_STORE: begin
          result_valid <= 1'b1;
          code_point <= code;
          {src_x, src_y, src_w, src_h} <= '0;
          {dst_x, dst_y, dst_w, dst_h} <= '0;
          if (found) status <= ST_STORED;
          else if (entry_count < CNT_W'(GLYPH_SLOTS)) begin
            status <= ST_STORED;
            entry_count <= entry_count + 1'b1;
          end else status <= ST_FULL;
          state <= S_IDLE;
        end
        S_READ: begin
          if (found) state <= S_MUL;
          else begin
            result_valid <= 1'b1;
            status <= ST_MISSING;
            code_point <= code;
            {src_x, src_y, src_w, src_h} <= '0;
            {dst_x, dst_y, dst_w, dst_h} <= '0;
            state <= S_IDLE;
          end
        end
        S_MUL: begin
          p_lh  <= row_pitch * scale;
          p_ox  <= met_rd.ox * $signed({1'b0, scale});
          p_oy  <= met_rd.oy * $signed({1'b0, scale});
          p_adv <= met_rd.adv * $signed({1'b0, scale});
          p_w   <= rect_rd.w * scale;
          p_h   <= rect_rd.h * scale;
          state <= newline ? S_SUM : S_OUT;
        end
        S_SUM: begin
          pen_x <= 32'(origin_x);
          pen_y <= sat32(34'(pen_y) + 34'(p_lh));
          state <= S_IDLE;
        end
        S_OUT: begin
          result_valid <= 1'b1;
          status <= ST_PLACED;
          code_point <= code;
          src_x <= rect_rd.x;
          src_y <= rect_rd.y;
          src_w <= rect_rd.w;
          src_h <= rect_rd.h;
          dst_x <= sat32(34'(pen_x) + 34'(p_ox));
          dst_y <= sat32(34'(pen_y) + 34'(p_oy));
          dst_w <= p_w;
          dst_h <= p_h;
          pen_x <= sat32(34'(pen_x) + 34'(p_adv));
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### src/ugtl_checker.sv
// Port-level checks for utf8_glyph_text_layout, bound to the top level.
// Depends on ugtl_pkg.
module ugtl_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic cfg_ready,
  input logic result_valid,
  input logic [1:0] status,
  input logic [27:0] dst_w
);
  import ugtl_pkg::*;

  a_no_result_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy)) else $error("result without item");
  a_start_blocks_cfg: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> !cfg_ready) else $error("config beside item");
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> !busy) else $error("config while busy");
  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid) else $error("strobe too long");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status != ST_PLACED) |-> dst_w == '0) else $error("miss fields");
endmodule

bind utf8_glyph_text_layout ugtl_checker u_chk (.*);
